### rtl/ptq_pkg.sv
`timescale 1ns / 1ps

package ptq_pkg;

    // default sizes of the slot table
    localparam int NUM_SLOTS_DEF  = 16;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int ID_WIDTH_DEF   = 16;

    // most tasks fired by one tick
    localparam int MAX_FIRE = 16;
    localparam int FC_W     = $clog2(MAX_FIRE + 1);

    // fixed field widths of the stream words
    localparam int CMD_W      = 3;
    localparam int SPAN_W     = 31;
    localparam int TID_W      = 16;
    localparam int REF_W      = 16;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SCHED    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SCHED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

    // slot table write strobes
    typedef struct packed {
        logic due_en;
        logic meta_en;
    } ptq_wr_t;

endpackage

### rtl/ptq_alu.sv
`timescale 1ns / 1ps

module ptq_alu
    import ptq_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic [TIME_WIDTH-1:0] op_a,
    input  logic [TIME_WIDTH-1:0] op_b,
    input  logic                  cin,
    input  logic [TIME_WIDTH-1:0] cmp_ref,
    output logic [TIME_WIDTH-1:0] sum,
    output logic                  gt,
    output logic                  win
);

    localparam logic [TIME_WIDTH-1:0] TOP = {1'b1, {(TIME_WIDTH-1){1'b0}}};

    // shared adder, wraps modulo 2^TIME_WIDTH
    assign sum = op_a + op_b + TIME_WIDTH'(cin);

    // unsigned compare of the age against the best so far
    assign gt = (sum > cmp_ref);

    // age in 0..TOP means the due time is not in the future
    assign win = !sum[TIME_WIDTH-1] || (sum == TOP);

endmodule

### rtl/ptq_slot_mem.sv
`timescale 1ns / 1ps

module ptq_slot_mem
    import ptq_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  logic                         aclk,
    input  ptq_wr_t                      wr,
    input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
    input  logic [TIME_WIDTH-1:0]        wr_due,
    input  logic [SPAN_W-1:0]            wr_period,
    input  logic [ID_WIDTH-1:0]          wr_ident,
    input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
    output logic [TIME_WIDTH-1:0]        rd_due,
    output logic [SPAN_W-1:0]            rd_period,
    output logic [ID_WIDTH-1:0]          rd_ident
);

    logic [TIME_WIDTH-1:0] due_mem    [NUM_SLOTS];
    logic [SPAN_W-1:0]     period_mem [NUM_SLOTS];
    logic [ID_WIDTH-1:0]   ident_mem  [NUM_SLOTS];

    // single write port
    always_ff @(posedge aclk) begin
        if (wr.due_en) begin
            due_mem[wr_addr] <= wr_due;
        end
        if (wr.meta_en) begin
            period_mem[wr_addr] <= wr_period;
            ident_mem[wr_addr]  <= wr_ident;
        end
    end

    // single registered read port
    always_ff @(posedge aclk) begin
        rd_due    <= due_mem[rd_addr];
        rd_period <= period_mem[rd_addr];
        rd_ident  <= ident_mem[rd_addr];
    end

endmodule

### rtl/periodic_timer_task_queue.sv
`timescale 1ns / 1ps

// Timer task table with periodic re-arm.
// Input words arrive on s_tvalid/s_tready; s_tuser carries the command
// (tick, schedule, cancel, complete, clear). Results leave on m_tvalid/m_tready,
// m_tuser gives the kind (schedule answer, fired, cancel answer), m_tlast marks
// the final result caused by one input word.
// One word is worked on at a time; s_tready is high only while idle.
// Tick, schedule, cancel and complete scan the slot table one slot per cycle
// through the single read port of the slot memory, comparing in one shared
// adder/comparator. Schedule, cancel and complete make one scan each. A tick
// that fires F tasks (0 < F < 16) makes one full scan per fired task plus a
// final empty scan and then sends the last result; a tick that fires 16 tasks
// skips the empty scan, and one that fires none makes a single scan.
// Clear all and unknown commands need no scan.
// Results sit in an output register; while the receiver stalls, the block
// waits before writing the next result, so nothing is lost.
// Reset (aresetn low, synchronous) empties the table, zeroes the time and
// id counters and drops any pending result; no memory clearing pass is needed.
module periodic_timer_task_queue
    import ptq_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // delay[30:0], interval[61:31], task_id[77:62], keep[78], zero[79]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd[2:0]
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // task_ref[15:0], status[17:16], zero[23:18]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind[1:0]
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_INC,
        S_SCAN,
        S_ACT,
        S_FLUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [SPAN_W-1:0]      delay_reg, delay_next;
    logic [SPAN_W-1:0]      interval_reg, interval_next;
    logic [TID_W-1:0]       tid_reg, tid_next;
    logic                   keep_reg, keep_next;
    logic [TIME_WIDTH-1:0]  now_reg, now_next;
    logic [ID_WIDTH-1:0]    next_id_reg, next_id_next;
    logic [NUM_SLOTS-1:0]   valid_reg, valid_next;
    logic [NUM_SLOTS-1:0]   flight_reg, flight_next;
    logic [NUM_SLOTS-1:0]   cancel_reg, cancel_next;
    logic [IDX_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                   issue_reg, issue_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [TIME_WIDTH-1:0]  best_age_reg, best_age_next;
    logic [ID_WIDTH-1:0]    best_ident_reg, best_ident_next;
    logic [SPAN_W-1:0]      best_period_reg, best_period_next;
    logic [FC_W-1:0]        fire_cnt_reg, fire_cnt_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic [REF_W-1:0]       pend_ref_reg, pend_ref_next;
    logic                   m_valid_reg, m_valid_next;
    logic [REF_W-1:0]       m_ref_reg, m_ref_next;
    logic [STAT_W-1:0]      m_status_reg, m_status_next;
    logic [KIND_W-1:0]      m_kind_reg, m_kind_next;
    logic                   m_last_reg, m_last_next;

    // slot memory and shared unit hookup
    ptq_wr_t                mem_wr;
    logic [TIME_WIDTH-1:0]  rd_due;
    logic [SPAN_W-1:0]      rd_period;
    logic [ID_WIDTH-1:0]    rd_ident;
    logic [TIME_WIDTH-1:0]  alu_a, alu_b, alu_sum;
    logic                   alu_cin, alu_gt, alu_win;

    // width adaptation of the fixed fields
    logic [TID_W+31:0]            tid_ext;
    logic [ID_WIDTH-1:0]          id_w;
    logic [ID_WIDTH+REF_W-1:0]    id_ref_ext, nid_ext, best_ref_ext;
    logic [SPAN_W+63:0]           delay_ext, period_ext;
    logic [TIME_WIDTH-1:0]        delay_t, period_t;
    logic                         accept, out_free, ident_eq, hit;

    assign tid_ext      = {32'd0, tid_reg};
    assign id_w         = tid_ext[ID_WIDTH-1:0];
    assign id_ref_ext   = {{REF_W{1'b0}}, id_w};
    assign nid_ext      = {{REF_W{1'b0}}, next_id_reg};
    assign best_ref_ext = {{REF_W{1'b0}}, best_ident_reg};
    assign delay_ext    = {64'd0, delay_reg};
    assign period_ext   = {64'd0, best_period_reg};
    assign delay_t      = delay_ext[TIME_WIDTH-1:0];
    assign period_t     = period_ext[TIME_WIDTH-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign ident_eq = (rd_ident == id_w);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-REF_W-STAT_W){1'b0}}, m_status_reg, m_ref_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    ptq_slot_mem #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TIME_WIDTH (TIME_WIDTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_mem (
        .aclk      (aclk),
        .wr        (mem_wr),
        .wr_addr   (best_idx_reg),
        .wr_due    (alu_sum),
        .wr_period (interval_reg),
        .wr_ident  (next_id_reg),
        .rd_addr   (rd_ptr_reg),
        .rd_due    (rd_due),
        .rd_period (rd_period),
        .rd_ident  (rd_ident)
    );

    ptq_alu #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_alu (
        .op_a    (alu_a),
        .op_b    (alu_b),
        .cin     (alu_cin),
        .cmp_ref (best_age_reg),
        .sum     (alu_sum),
        .gt      (alu_gt),
        .win     (alu_win)
    );

    // operand select for the shared adder
    always_comb begin
        alu_a   = now_reg;
        alu_b   = ~rd_due;
        alu_cin = 1'b1;
        case (state_reg)
            S_TICK_INC: begin
                alu_b = '0;
            end
            S_ACT: begin
                if (cmd_reg == CMD_SCHED) begin
                    alu_b = delay_t;
                end else begin
                    alu_b   = period_t;
                    alu_cin = 1'b0;
                end
            end
            default: begin
                alu_b = ~rd_due;
            end
        endcase
    end

    // match test on the slot coming out of memory
    always_comb begin
        case (cmd_reg)
            CMD_TICK:
                hit = valid_reg[chk_idx_reg] && !flight_reg[chk_idx_reg] && alu_win
                      && (!found_reg || alu_gt);
            CMD_SCHED:
                hit = !valid_reg[chk_idx_reg] && !found_reg;
            CMD_CANCEL:
                hit = valid_reg[chk_idx_reg] && ident_eq && !found_reg;
            CMD_COMPLETE:
                hit = valid_reg[chk_idx_reg] && flight_reg[chk_idx_reg] && ident_eq
                      && !found_reg;
            default:
                hit = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        delay_next       = delay_reg;
        interval_next    = interval_reg;
        tid_next         = tid_reg;
        keep_next        = keep_reg;
        now_next         = now_reg;
        next_id_next     = next_id_reg;
        valid_next       = valid_reg;
        flight_next      = flight_reg;
        cancel_next      = cancel_reg;
        rd_ptr_next      = rd_ptr_reg;
        issue_next       = issue_reg;
        chk_vld_next     = (state_reg == S_SCAN) && issue_reg;
        chk_idx_next     = rd_ptr_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_age_next    = best_age_reg;
        best_ident_next  = best_ident_reg;
        best_period_next = best_period_reg;
        fire_cnt_next    = fire_cnt_reg;
        pend_vld_next    = pend_vld_reg;
        pend_ref_next    = pend_ref_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_ref_next       = m_ref_reg;
        m_status_next    = m_status_reg;
        m_kind_next      = m_kind_reg;
        m_last_next      = m_last_reg;
        mem_wr           = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next      = s_tuser;
                    delay_next    = s_tdata[30:0];
                    interval_next = s_tdata[61:31];
                    tid_next      = s_tdata[77:62];
                    keep_next     = s_tdata[78];
                    fire_cnt_next = '0;
                    pend_vld_next = 1'b0;
                    rd_ptr_next   = '0;
                    issue_next    = 1'b1;
                    found_next    = 1'b0;
                    case (s_tuser)
                        CMD_TICK: begin
                            state_next = S_TICK_INC;
                        end
                        CMD_SCHED, CMD_CANCEL, CMD_COMPLETE: begin
                            state_next = S_SCAN;
                        end
                        CMD_CLEAR: begin
                            valid_next  = '0;
                            flight_next = '0;
                            cancel_next = '0;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // advance time, then scan for the earliest due slot
            S_TICK_INC: begin
                now_next   = alu_sum;
                state_next = S_SCAN;
            end

            // one slot read per cycle, checked in the cycle after its read
            S_SCAN: begin
                if (issue_reg) begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    if (rd_ptr_reg == LAST_IDX) begin
                        issue_next = 1'b0;
                    end
                end
                if (chk_vld_reg) begin
                    if (hit) begin
                        found_next       = 1'b1;
                        best_idx_next    = chk_idx_reg;
                        best_age_next    = alu_sum;
                        best_ident_next  = rd_ident;
                        best_period_next = rd_period;
                    end
                    if (chk_idx_reg == LAST_IDX) begin
                        state_next = S_ACT;
                    end
                end
            end

            S_ACT: begin
                case (cmd_reg)
                    CMD_TICK: begin
                        if (found_reg) begin
                            if (!pend_vld_reg || out_free) begin
                                flight_next[best_idx_reg] = 1'b1;
                                fire_cnt_next = fire_cnt_reg + 1'b1;
                                if (pend_vld_reg) begin
                                    m_valid_next  = 1'b1;
                                    m_ref_next    = pend_ref_reg;
                                    m_status_next = STAT_OK;
                                    m_kind_next   = KIND_FIRE;
                                    m_last_next   = 1'b0;
                                end
                                pend_vld_next = 1'b1;
                                pend_ref_next = best_ref_ext[REF_W-1:0];
                                if (fire_cnt_reg == FC_W'(MAX_FIRE - 1)) begin
                                    state_next = S_FLUSH;
                                end else begin
                                    state_next  = S_SCAN;
                                    rd_ptr_next = '0;
                                    issue_next  = 1'b1;
                                    found_next  = 1'b0;
                                end
                            end
                        end else if (pend_vld_reg) begin
                            state_next = S_FLUSH;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                    CMD_SCHED: begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_SCHED;
                            m_last_next  = 1'b1;
                            if (found_reg) begin
                                mem_wr.due_en  = 1'b1;
                                mem_wr.meta_en = 1'b1;
                                valid_next[best_idx_reg]  = 1'b1;
                                flight_next[best_idx_reg] = 1'b0;
                                cancel_next[best_idx_reg] = 1'b0;
                                m_ref_next    = nid_ext[REF_W-1:0];
                                m_status_next = STAT_OK;
                                next_id_next  = next_id_reg + 1'b1;
                            end else begin
                                m_ref_next    = '0;
                                m_status_next = STAT_FULL;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_CANCEL: begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_CANCEL;
                            m_last_next  = 1'b1;
                            m_ref_next   = id_ref_ext[REF_W-1:0];
                            if (found_reg) begin
                                m_status_next = STAT_OK;
                                if (flight_reg[best_idx_reg]) begin
                                    cancel_next[best_idx_reg] = 1'b1;
                                end else begin
                                    valid_next[best_idx_reg]  = 1'b0;
                                    flight_next[best_idx_reg] = 1'b0;
                                    cancel_next[best_idx_reg] = 1'b0;
                                end
                            end else begin
                                m_status_next = STAT_NOT_FOUND;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_COMPLETE: begin
                        if (found_reg) begin
                            if ((best_period_reg != '0) && keep_reg
                                    && !cancel_reg[best_idx_reg]) begin
                                // re-arm at now plus period
                                mem_wr.due_en = 1'b1;
                                flight_next[best_idx_reg] = 1'b0;
                            end else begin
                                valid_next[best_idx_reg]  = 1'b0;
                                flight_next[best_idx_reg] = 1'b0;
                                cancel_next[best_idx_reg] = 1'b0;
                            end
                        end
                        state_next = S_IDLE;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // last fired task of this tick
            S_FLUSH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_ref_next    = pend_ref_reg;
                    m_status_next = STAT_OK;
                    m_kind_next   = KIND_FIRE;
                    m_last_next   = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            now_reg      <= '0;
            next_id_reg  <= '0;
            valid_reg    <= '0;
            flight_reg   <= '0;
            cancel_reg   <= '0;
            issue_reg    <= 1'b0;
            chk_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            fire_cnt_reg <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            next_id_reg  <= next_id_next;
            valid_reg    <= valid_next;
            flight_reg   <= flight_next;
            cancel_reg   <= cancel_next;
            issue_reg    <= issue_next;
            chk_vld_reg  <= chk_vld_next;
            found_reg    <= found_next;
            fire_cnt_reg <= fire_cnt_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg         <= cmd_next;
        delay_reg       <= delay_next;
        interval_reg    <= interval_next;
        tid_reg         <= tid_next;
        keep_reg        <= keep_next;
        rd_ptr_reg      <= rd_ptr_next;
        chk_idx_reg     <= chk_idx_next;
        best_idx_reg    <= best_idx_next;
        best_age_reg    <= best_age_next;
        best_ident_reg  <= best_ident_next;
        best_period_reg <= best_period_next;
        pend_ref_reg    <= pend_ref_next;
        m_ref_reg       <= m_ref_next;
        m_status_reg    <= m_status_next;
        m_kind_reg      <= m_kind_next;
        m_last_reg      <= m_last_next;
    end

`ifndef NO_ASSERTIONS
    // a slot is only in flight while it is valid
    a_flight_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (flight_reg & ~valid_reg) == '0)
        else $error("in-flight mark on a free slot");

    // a cancelled mark only stands on an in-flight slot
    a_cancel_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (cancel_reg & ~flight_reg) == '0)
        else $error("cancelled mark on a slot not in flight");

    // one tick never fires more than the limit
    a_fire_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_cnt_reg <= FC_W'(MAX_FIRE))
        else $error("tick fired too many tasks");

    // fired results always carry status ok
    a_fire_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_kind_reg == KIND_FIRE) |-> (m_status_reg == STAT_OK))
        else $error("fired result with bad status");

    // busy right after a word that needs a table scan is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser <= CMD_COMPLETE) |=> !s_tready)
        else $error("ready right after accepting a word");
`endif

endmodule
